// File: sv/condorcet_winner_assert.svh
`ifndef CONDORCET_WINNER_ASSERT_SVH
`define CONDORCET_WINNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied
`define CW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cw assertion failed");

// Next-cycle implication, disabled while reset is applied
`define CW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cw assertion failed");

`endif

// File: sv/cw_pkg.sv
package cw_pkg;

    // Default sizes
    localparam int MAX_CANDIDATES_DEF = 16;
    localparam int COUNT_WIDTH_DEF    = 16;

    // Fixed field widths
    localparam int CAND_W = 4;
    localparam int NUMC_W = 5;
    localparam logic [NUMC_W-1:0] NUMC_RESET = 5'd3;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_NUM_CANDIDATES = 1'b0;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr;        // write zero at {row, col}
        logic tally_rd;   // read [row][cand] for increment
        logic ballot_upd; // update seen mask and rank position
        logic chk_rd;     // read [row][col] and [col][row]
        logic chk_start;  // start a new candidate check
        logic res_set;    // capture the check outcome
        logic out_load;   // load the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result
        logic last;       // current item ends the election
        logic beats;      // candidate under check still beats all so far
    } t_dp_sts;

endpackage

// File: sv/cw_ctrl.sv
module cw_ctrl #(
    parameter int MAX_CANDIDATES = cw_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(MAX_CANDIDATES+1)-1:0]  i_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  cw_pkg::t_dp_sts                      i_sts,
    output cw_pkg::t_dp_cmd                      o_cmd,
    output logic [$clog2(MAX_CANDIDATES)-1:0]    o_row,
    output logic [$clog2(MAX_CANDIDATES)-1:0]    o_col
);
    import cw_pkg::*;

    localparam int IDX_W = $clog2(MAX_CANDIDATES);
    localparam int N_W   = $clog2(MAX_CANDIDATES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TALLY,
        ST_TALLY_END,
        ST_CHECK,
        ST_CHECK_END,
        ST_RESULT
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_col, n_col;
    logic [IDX_W-1:0]  w_last_idx;
    t_dp_cmd           w_cmd;
    logic              w_ready;

    // Highest candidate index in use
    assign w_last_idx = IDX_W'(i_n - N_W'(1));

    // Next state, loop counters and commands
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        w_cmd   = '0;
        w_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                // sweep every matrix entry once
                w_cmd.clr = 1'b1;
                n_col     = r_col + 1'b1;
                if (&r_col) begin
                    n_row = r_row + 1'b1;
                    if (&r_row) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    n_row   = '0;
                    n_state = ST_TALLY;
                end
            end
            ST_TALLY: begin
                // one candidate row per cycle; only rows ranked earlier are incremented
                w_cmd.tally_rd = 1'b1;
                if (r_row == w_last_idx) begin
                    n_state = ST_TALLY_END;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_TALLY_END: begin
                // last write-back lands here
                w_cmd.ballot_upd = 1'b1;
                if (i_sts.last) begin
                    n_row           = '0;
                    n_col           = '0;
                    w_cmd.chk_start = 1'b1;
                    n_state         = ST_CHECK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHECK: begin
                // one opponent per cycle
                w_cmd.chk_rd = 1'b1;
                if (r_col == w_last_idx) begin
                    n_state = ST_CHECK_END;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_CHECK_END: begin
                if (i_sts.beats || (r_row == w_last_idx)) begin
                    w_cmd.res_set = 1'b1;
                    n_state       = ST_RESULT;
                end else begin
                    n_row           = r_row + 1'b1;
                    n_col           = '0;
                    w_cmd.chk_start = 1'b1;
                    n_state         = ST_CHECK;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_row          = '0;
                    n_col          = '0;
                    n_state        = ST_CLEAR;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_row   = '0;
                n_col   = '0;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = w_ready;
    assign o_row      = r_row;
    assign o_col      = r_col;

endmodule

// File: sv/cw_dpath.sv
module cw_dpath #(
    parameter int MAX_CANDIDATES = cw_pkg::MAX_CANDIDATES_DEF,
    parameter int COUNT_WIDTH    = cw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(MAX_CANDIDATES+1)-1:0]  i_n,
    input  cw_pkg::t_dp_cmd                      i_cmd,
    output cw_pkg::t_dp_sts                      o_sts,
    input  logic [$clog2(MAX_CANDIDATES)-1:0]    i_row,
    input  logic [$clog2(MAX_CANDIDATES)-1:0]    i_col,
    input  logic                                 i_accept,
    input  logic [cw_pkg::CAND_W-1:0]            i_cand,
    input  logic                                 i_last,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic                                 o_winner_found,
    output logic [cw_pkg::CAND_W-1:0]            o_winner_index,
    output logic                                 o_count_saturated
);
    import cw_pkg::*;

    localparam int IDX_W  = $clog2(MAX_CANDIDATES);
    localparam int N_W    = $clog2(MAX_CANDIDATES + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Pairwise count matrix, address {row, col}
    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_a, r_rd_b;
    logic [ADDR_W-1:0]      w_raddr_a, w_raddr_b, w_waddr;
    logic [COUNT_WIDTH-1:0] w_wdata, w_inc;
    logic                   w_we;

    // Current item
    logic [CAND_W-1:0]      r_cand;
    logic                   r_last;
    logic                   w_cand_ok;
    logic [IDX_W-1:0]       w_cand_idx;

    // Ballot state
    logic [MAX_CANDIDATES-1:0] r_seen, n_seen;
    logic [N_W-1:0]            r_rank, n_rank;
    logic                      r_sat;

    // Increment pipeline
    logic                   r_wb_vld;
    logic [IDX_W-1:0]       r_wb_row;
    logic                   w_wb_en;

    // Check pipeline
    logic                   r_ck_vld, r_ck_diff;
    logic                   r_beats, w_fail, w_beats;
    logic                   r_res_found;
    logic [IDX_W-1:0]       r_res_who;

    // Output register
    logic                   r_out_vld;

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cand <= i_cand;
            r_last <= i_last;
        end
    end

    assign w_cand_ok  = 32'(r_cand) < 32'(i_n);
    assign w_cand_idx = IDX_W'(32'(r_cand));

    // Memory ports
    assign w_raddr_a = {i_row, (i_cmd.tally_rd ? w_cand_idx : i_col)};
    assign w_raddr_b = {i_col, i_row};
    assign w_inc     = (r_rd_a == CNT_MAX) ? CNT_MAX : r_rd_a + 1'b1;
    assign w_wb_en   = r_wb_vld && w_cand_ok && r_seen[r_wb_row] && (r_wb_row != w_cand_idx);
    assign w_we      = i_cmd.clr || w_wb_en;
    assign w_waddr   = i_cmd.clr ? {i_row, i_col} : {r_wb_row, w_cand_idx};
    assign w_wdata   = i_cmd.clr ? '0 : w_inc;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    // Read tags are registered alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
            r_ck_vld <= 1'b0;
        end else begin
            r_wb_vld <= i_cmd.tally_rd;
            r_ck_vld <= i_cmd.chk_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_row  <= i_row;
        r_ck_diff <= (i_row != i_col);
    end

    // Seen mask and rank position after an item
    always_comb begin
        n_seen = r_seen;
        n_rank = r_rank + 1'b1;
        if (w_cand_ok) begin
            n_seen[w_cand_idx] = 1'b1;
        end
        if ((n_rank >= i_n) || r_last) begin
            n_seen = '0;
            n_rank = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_rank <= '0;
        end else if (i_cmd.ballot_upd) begin
            r_seen <= n_seen;
            r_rank <= n_rank;
        end
    end

    // Sticky saturation flag, cleared when the result is loaded into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (w_wb_en && (w_inc == CNT_MAX)) begin
            r_sat <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_sat <= 1'b0;
        end
    end

    // Candidate check: fails once [a][b] <= [b][a]
    assign w_fail  = r_ck_vld && r_ck_diff && (r_rd_a <= r_rd_b);
    assign w_beats = r_beats && !w_fail;

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_start) begin
            r_beats <= 1'b1;
        end else if (w_fail) begin
            r_beats <= 1'b0;
        end
        if (i_cmd.res_set) begin
            r_res_found <= w_beats;
            r_res_who   <= w_beats ? i_row : '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_winner_found    <= r_res_found;
            o_winner_index    <= CAND_W'(32'(r_res_who));
            o_count_saturated <= r_sat;
        end
    end

    assign o_m_tvalid     = r_out_vld;
    assign o_sts.out_free = !r_out_vld || i_m_tready;
    assign o_sts.last     = r_last;
    assign o_sts.beats    = w_beats;

endmodule

// File: sv/condorcet_winner.sv
// Channel   Dir  Handshake              Payload
// s stream  in   i_s_tvalid/o_s_tready  tdata[3:0] ranked_candidate, tlast end_of_election
// m stream  out  o_m_tvalid/i_m_tready  tdata[0] found, [4:1] index, [5] saturated
// config    in   psel/penable/pready    reg 0 num_candidates at byte address 0
//
// Each item is taken in an accept step, then n read-modify-write steps on the single write port of the
// pair count memory (n = candidates in effect) and one write-back step follow.
// The final item then checks candidates in order against every opponent, stopping at the first
// winner, loads the result (waiting while the output register is still full) and sweeps all
// 2^(2*ceil(log2(MAX_CANDIDATES))) memory entries clear (256 at 16), one entry a cycle.
// After reset the same clear sweep runs before the first item is taken.
// A waiting result does not stall tallying; only the next result waits for it.
module condorcet_winner #(
    parameter int MAX_CANDIDATES = cw_pkg::MAX_CANDIDATES_DEF,
    parameter int COUNT_WIDTH    = cw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [cw_pkg::S_TDATA_W-1:0]    i_s_tdata,  // [3:0] ranked_candidate, rest zero
    input  logic                            i_s_tlast,  // end_of_election
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cw_pkg::M_TDATA_W-1:0]    o_m_tdata,  // [0] winner_found,
                                                        // [4:1] winner_index,
                                                        // [5] count_saturated, rest zero
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                            pready
);
    import cw_pkg::*;

    localparam int IDX_W = $clog2(MAX_CANDIDATES);
    localparam int N_W   = $clog2(MAX_CANDIDATES + 1);

    logic [NUMC_W-1:0] r_num_cand;
    logic              w_cfg_sel;
    logic [N_W-1:0]    w_n;
    logic              w_accept;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [IDX_W-1:0]  w_row, w_col;
    logic              w_found, w_sat;
    logic [CAND_W-1:0] w_index;

    // Config register
    assign w_cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_NUM_CANDIDATES);
    assign pready    = 1'b1;
    assign prdata    = w_cfg_sel ? APB_DATA_W'(r_num_cand) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cand <= NUMC_RESET;
        end else if (psel && penable && pwrite && w_cfg_sel) begin
            r_num_cand <= pwdata[NUMC_W-1:0];
        end
    end

    // Candidates in effect, held to 1 .. MAX_CANDIDATES
    always_comb begin
        if (r_num_cand == '0) begin
            w_n = N_W'(1);
        end else if (32'(r_num_cand) > MAX_CANDIDATES) begin
            w_n = N_W'(MAX_CANDIDATES);
        end else begin
            w_n = N_W'(r_num_cand);
        end
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    cw_ctrl #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (w_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_row      (w_row),
        .o_col      (w_col)
    );

    cw_dpath #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_n               (w_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_row             (w_row),
        .i_col             (w_col),
        .i_accept          (w_accept),
        .i_cand            (i_s_tdata[CAND_W-1:0]),
        .i_last            (i_s_tlast),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_winner_found    (w_found),
        .o_winner_index    (w_index),
        .o_count_saturated (w_sat)
    );

    // Pack result fields
    assign o_m_tdata = M_TDATA_W'({w_sat, w_index, w_found});

endmodule

// File: sv/cw_checker.sv
`include "condorcet_winner_assert.svh"

module cw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [cw_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    // A stalled result holds
    `CW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // The block is not ready in the cycle after taking an item
    `CW_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // No winner means index zero
    `CW_ASSERT_NOW(a_no_winner_idx, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[0], o_m_tdata[4:1] == 4'd0)

    // Pad bits of the result stay zero
    `CW_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[7:6] == 2'd0)

endmodule

bind condorcet_winner cw_checker u_cw_checker (.*);
